// File: hdl/m4vt_pkg.sv
// ----------------------------------------------------------------------------
// m4vt_pkg
// Shared types and constants for the 4x4 matrix vector transform.
// ----------------------------------------------------------------------------
`default_nettype none

package m4vt_pkg;

	// signed Q16.16 word
	typedef logic signed [31:0] q16_t;

	// four Q16.16 words, index 0 is x
	typedef logic [3:0][31:0] quad_t;

	// matrix register file geometry
	localparam int unsigned NUM_PAIRS = 8;
	localparam int unsigned PAIR_W    = 64;
	localparam int unsigned CFG_IDX_W = 8;
	localparam int unsigned PAIR_IDX_W = $clog2(NUM_PAIRS);

	// pipeline datapath widths
	localparam int unsigned PROD_W = 64;
	localparam int unsigned TERM_W = 48;
	localparam int unsigned PSUM_W = TERM_W + 1;
	localparam int unsigned SUM_W  = TERM_W + 2;

	// identity matrix reset values
	localparam logic [PAIR_W-1:0] PAIR_ONE_LO = 64'h0000_0000_0001_0000;
	localparam logic [PAIR_W-1:0] PAIR_ONE_HI = 64'h0001_0000_0000_0000;
	localparam logic [PAIR_W-1:0] PAIR_ZERO   = 64'h0;

	// reset value of each pair register, identity matrix
	localparam logic [PAIR_W-1:0] PAIR_RESET [NUM_PAIRS] = '{
		PAIR_ONE_LO, PAIR_ZERO, PAIR_ONE_HI, PAIR_ZERO,
		PAIR_ZERO, PAIR_ONE_LO, PAIR_ZERO, PAIR_ONE_HI
	};

	// per-stage advance enables
	typedef struct packed {
		logic s1;
		logic s2;
		logic s3;
	} stage_en_t;

endpackage

`default_nettype wire

// File: hdl/m4vt_vec_if.sv
// ----------------------------------------------------------------------------
// m4vt_vec_if
// Input vector channel: valid/ready with one vector per beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface m4vt_vec_if;
	import m4vt_pkg::*;

	logic valid;
	logic ready;
	q16_t vec_x;
	q16_t vec_y;
	q16_t vec_z;
	q16_t vec_w;

	modport source (output valid, output vec_x, output vec_y, output vec_z,
		output vec_w, input ready);
	modport sink (input valid, input vec_x, input vec_y, input vec_z,
		input vec_w, output ready);
endinterface

`default_nettype wire

// File: hdl/m4vt_res_if.sv
// ----------------------------------------------------------------------------
// m4vt_res_if
// Result vector channel: valid/ready with one transformed vector per beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface m4vt_res_if;
	import m4vt_pkg::*;

	logic valid;
	logic ready;
	q16_t res_x;
	q16_t res_y;
	q16_t res_z;
	q16_t res_w;

	modport source (output valid, output res_x, output res_y, output res_z,
		output res_w, input ready);
	modport sink (input valid, input res_x, input res_y, input res_z,
		input res_w, output ready);
endinterface

`default_nettype wire

// File: hdl/m4vt_cfg_if.sv
// ----------------------------------------------------------------------------
// m4vt_cfg_if
// Configuration write channel: register index and 64-bit data per beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface m4vt_cfg_if;
	import m4vt_pkg::*;

	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [PAIR_W-1:0]    data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// File: hdl/matrix4_vector_transform.sv
// ----------------------------------------------------------------------------
// matrix4_vector_transform
// Each accepted input beat is registered in stages 1, 2 and 3 before its result beat.
// Throughput: one vector per cycle while the output is not stalled; four dot-product lanes, each a
// multiply / pairwise-add / final-add-and-saturate pipeline.
// A stalled output holds each occupied stage in place through a per-stage ready chain.
// Reset: pipeline valid bits clear and the matrix returns to identity.
// ----------------------------------------------------------------------------
`default_nettype none

module matrix4_vector_transform (
	input  wire  clk,
	input  wire  arst_n,
	m4vt_vec_if.sink   in,
	m4vt_res_if.source out,
	m4vt_cfg_if.sink   cfg
);
	import m4vt_pkg::*;

	logic [PAIR_W-1:0] pair_q [NUM_PAIRS];

	logic      valid_s1;
	logic      valid_s2;
	logic      valid_s3;
	logic      rdy1;
	logic      rdy2;
	logic      rdy3;
	stage_en_t en;
	quad_t     vec;
	quad_t     elem;
	quad_t     row [4];
	q16_t      res [4];

	// matrix register writes, out-of-range indexes are dropped
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < NUM_PAIRS; k++) begin
				pair_q[k] <= PAIR_RESET[k];
			end
		end else if (cfg.valid && (cfg.index < CFG_IDX_W'(NUM_PAIRS))) begin
			pair_q[cfg.index[PAIR_IDX_W-1:0]] <= cfg.data;
		end
	end

	// stage ready chain
	assign rdy3     = !valid_s3 || out.ready;
	assign rdy2     = !valid_s2 || rdy3;
	assign rdy1     = !valid_s1 || rdy2;
	assign in.ready = rdy1;
	assign en       = '{s1: rdy1, s2: rdy2, s3: rdy3};

	// valid bits travel with the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (rdy1) valid_s1 <= in.valid;
			if (rdy2) valid_s2 <= valid_s1;
			if (rdy3) valid_s3 <= valid_s2;
		end
	end

	// input vector and per-row matrix elements, column-major
	assign vec = {in.vec_w, in.vec_z, in.vec_y, in.vec_x};

	always_comb begin
		for (int r = 0; r < 4; r++) begin
			for (int c = 0; c < 4; c++) begin
				elem[c] = pair_q[(r + 4 * c) / 2][32 * ((r + 4 * c) % 2) +: 32];
			end
			row[r] = elem;
		end
	end

	// one lane per output component
	for (genvar r = 0; r < 4; r++) begin : g_lane
		m4vt_dot_lane u_lane (
			.clk (clk),
			.en  (en),
			.vec (vec),
			.row (row[r]),
			.res (res[r])
		);
	end

	// result beat
	assign out.valid = valid_s3;
	assign out.res_x = res[0];
	assign out.res_y = res[1];
	assign out.res_z = res[2];
	assign out.res_w = res[3];

endmodule

`default_nettype wire

// File: hdl/m4vt_dot_lane.sv
// ----------------------------------------------------------------------------
// m4vt_dot_lane
// Three-stage dot product of one matrix row with the vector: multiply,
// truncate and pairwise add, final add with saturation to 32 bits.
// ----------------------------------------------------------------------------
`default_nettype none

module m4vt_dot_lane (
	input  wire                      clk,
	input  wire m4vt_pkg::stage_en_t en,
	input  wire m4vt_pkg::quad_t     vec,
	input  wire m4vt_pkg::quad_t     row,
	output m4vt_pkg::q16_t           res
);
	import m4vt_pkg::*;

	logic signed [PROD_W-1:0] prod_s1 [4];
	logic signed [PSUM_W-1:0] psum_s2 [2];
	q16_t                     res_s3;

	logic signed [TERM_W-1:0] term   [4];
	logic signed [SUM_W-1:0]  sum;
	q16_t                     sat;

	// stage 1: four full-precision products
	always_ff @(posedge clk) begin
		if (en.s1) begin
			for (int c = 0; c < 4; c++) begin
				prod_s1[c] <= $signed(vec[c]) * $signed(row[c]);
			end
		end
	end

	// drop 16 fraction bits, floor rounding
	always_comb begin
		for (int c = 0; c < 4; c++) begin
			term[c] = prod_s1[c][PROD_W-1:16];
		end
	end

	// stage 2: pairwise sums
	always_ff @(posedge clk) begin
		if (en.s2) begin
			psum_s2[0] <= PSUM_W'(term[0]) + PSUM_W'(term[1]);
			psum_s2[1] <= PSUM_W'(term[2]) + PSUM_W'(term[3]);
		end
	end

	// final sum and clamp to the signed 32-bit range
	always_comb begin
		sum = SUM_W'(psum_s2[0]) + SUM_W'(psum_s2[1]);
		if (sum > SUM_W'(signed'(32'sh7FFF_FFFF))) begin
			sat = 32'sh7FFF_FFFF;
		end else if (sum < SUM_W'(signed'(32'sh8000_0000))) begin
			sat = 32'sh8000_0000;
		end else begin
			sat = sum[31:0];
		end
	end

	// stage 3: saturated result
	always_ff @(posedge clk) begin
		if (en.s3) begin
			res_s3 <= sat;
		end
	end

	assign res = res_s3;

endmodule

`default_nettype wire
